FILE: design/dmxsr_pkg.sv
package dmxsr_pkg;

   // line event codes carried in the cmd field
   localparam logic [2:0] CMD_BYTE  = 3'd0;
   localparam logic [2:0] CMD_BREAK = 3'd1;
   localparam logic [2:0] CMD_IDLE  = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_TICK  = 3'd4;

   localparam int unsigned CMD_W     = 3;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CHAN_W    = 10;
   localparam int unsigned TIMEOUT_W = 16;
   localparam int unsigned STATE_W   = 2;

   // the read channel is clamped to 1..512, so entries span 512
   localparam int unsigned STORE_DEPTH = 512;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
   localparam int unsigned FILL_W      = $clog2(STORE_DEPTH + 1);

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = '1;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic               healthy;
      logic [STATE_W-1:0] frame_state;
   } frame_status_type;

   // channel 0 reads channel 1, channels above the store read its last entry
   function automatic logic [ADDR_W-1:0] clamp_entry(input logic [CHAN_W-1:0] chan);
      logic [ADDR_W-1:0] entry;
      entry = '0;
      if (chan == '0) begin
         entry = '0;
      end else if (chan > CHAN_W'(STORE_DEPTH)) begin
         entry = ADDR_W'(STORE_DEPTH - 1);
      end else begin
         entry = ADDR_W'(chan - CHAN_W'(1));
      end
      return entry;
   endfunction

endpackage

FILE: design/dmxsr_if.sv
interface dmxsr_req_if import dmxsr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] data_byte;
   logic [CHAN_W-1:0] channel;

   modport source (output valid, cmd, data_byte, channel, input ready);
   modport sink (input valid, cmd, data_byte, channel, output ready);
endinterface

interface dmxsr_rsp_if import dmxsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  read_value;
   logic               healthy;
   logic [STATE_W-1:0] frame_state;

   modport source (output valid, read_value, healthy, frame_state, input ready);
   modport sink (input valid, read_value, healthy, frame_state, output ready);
endinterface

FILE: design/dmxsr_slot_store.sv
module dmxsr_slot_store import dmxsr_pkg::*; #(
   parameter int unsigned DEPTH = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  store_wr_type        wr,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [BYTE_W-1:0]   rd_data,
   output logic                rd_hit
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_hit_ff;
   logic              rd_hit_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [ADDR_W-1:0] rd_index;

   // slots are always written in order from entry 0, so every entry below
   // the fill mark has been written and every entry at or above it reads with rd_hit low
   always_comb begin
      fill_in = fill_ff;
      if (wr.en && (FILL_W'(wr.addr) == fill_ff)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   assign rd_hit_in = (FILL_W'(rd_addr) < fill_ff);
   assign rd_index  = (FILL_W'(rd_addr) < FILL_W'(DEPTH)) ? rd_addr : '0;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd_en) begin
            rd_hit_ff <= rd_hit_in;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

FILE: design/dmxsr_frame_ctrl.sv
module dmxsr_frame_ctrl import dmxsr_pkg::*; #(
   parameter int unsigned SLOT_COUNT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [CMD_W-1:0]     cmd,
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic                 timeout_we,
   input  logic [TIMEOUT_W-1:0] timeout_wdata,
   output store_wr_type         wr,
   output frame_status_type     status_next
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT + 1);

   typedef enum logic [STATE_W-1:0] {
      MODE_IDLE       = 2'd0,
      MODE_WAIT_START = 2'd1,
      MODE_SLOTS      = 2'd2
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [IDX_W-1:0]     slot_index_ff, slot_index_in;
   logic [TIMEOUT_W-1:0] ticks_ff, ticks_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   always_comb begin
      mode_in       = mode_ff;
      slot_index_in = slot_index_ff;
      ticks_in      = ticks_ff;
      timeout_in    = timeout_we ? timeout_wdata : timeout_ff;
      wr.en         = 1'b0;
      wr.addr       = ADDR_W'(slot_index_ff);
      wr.data       = data_byte;
      if (accept) begin
         case (cmd)
            CMD_BYTE: begin
               unique case (mode_ff)
                  MODE_WAIT_START: begin
                     // only a zero start code opens a frame
                     if (data_byte == '0) begin
                        mode_in       = MODE_SLOTS;
                        slot_index_in = '0;
                        ticks_in      = '0;
                     end
                  end
                  MODE_SLOTS: begin
                     if (slot_index_ff < IDX_W'(SLOT_COUNT)) begin
                        wr.en         = 1'b1;
                        slot_index_in = slot_index_ff + IDX_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_BREAK: mode_in = MODE_WAIT_START;
            CMD_READ: begin
            end
            CMD_TICK: begin
               if (ticks_ff != TICKS_MAX) begin
                  ticks_in = ticks_ff + TIMEOUT_W'(1);
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
      status_next.healthy     = (ticks_in < timeout_ff);
      status_next.frame_state = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         slot_index_ff <= '0;
         ticks_ff      <= '0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         mode_ff       <= mode_in;
         slot_index_ff <= slot_index_in;
         ticks_ff      <= ticks_in;
         timeout_ff    <= timeout_in;
      end
   end

endmodule

FILE: design/dmx512_slot_receiver_unit.sv
// dmx512 slot receiver: takes one line event per item (received byte, break,
// go-idle, channel read, tick) and returns exactly one result item per event,
// showing the read value, the health flag and the frame state after that
// event. a new item is accepted every cycle unless a stalled result holds
// stage one; each item passes through two register stages (the slot store
// read register, then the result register). the result register and the
// store read stage together let the block take one more item while a
// finished result waits. the slot store is a single 512-entry memory
// written at one address and read at one address per cycle; after reset it
// reads as all zeros at once with no clearing pass, since a fill mark tracks
// how far slots have been written.
// csr_write_data sets the health timeout in ticks (reset 500) and should only
// be written while no items are in flight.
module dmx512_slot_receiver_unit import dmxsr_pkg::*; #(
   parameter int unsigned SLOT_COUNT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   dmxsr_req_if.sink            req_chan,
   dmxsr_rsp_if.source          rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [TIMEOUT_W-1:0] csr_write_data
);

   logic             req_accept;
   logic             s1_advance;
   store_wr_type     store_wr;
   frame_status_type status_next;
   logic [BYTE_W-1:0] store_rd_data;
   logic             store_rd_hit;

   // stage one: item accepted, store read in flight
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_read_ff;
   frame_status_type s1_status_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_value_ff;
   frame_status_type  rsp_status_ff;

   // stage one moves on when the result register is empty or being drained
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_chan.ready);

   // mode, slot index, tick counter and timeout register
   dmxsr_frame_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_frame_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .cmd           (req_chan.cmd),
      .data_byte     (req_chan.data_byte),
      .timeout_we    (csr_write_enable),
      .timeout_wdata (csr_write_data),
      .wr            (store_wr),
      .status_next   (status_next)
   );

   // slot values, read at the clamped channel of each accepted item
   dmxsr_slot_store #(
      .DEPTH (SLOT_COUNT)
   ) u_slot_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (store_wr),
      .rd_en   (req_accept),
      .rd_addr (clamp_entry(req_chan.channel)),
      .rd_data (store_rd_data),
      .rd_hit  (store_rd_hit)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_read_ff   <= (req_chan.cmd == CMD_READ);
         s1_status_ff <= status_next;
      end
      if (s1_advance) begin
         // unread or never-written entries give zero
         rsp_value_ff  <= (s1_read_ff && store_rd_hit) ? store_rd_data : '0;
         rsp_status_ff <= s1_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.healthy     = rsp_status_ff.healthy;
   assign rsp_chan.frame_state = rsp_status_ff.frame_state;

endmodule
